// File: hw/rtl/cht_pkg.sv
// Cookie header tokenizer package: beat types, result kinds, parse modes,
// sequencer states and character constants. No dependencies.
`default_nettype none

package cht_pkg;

  localparam int CHT_NAME_MAX       = 64;
  localparam int CHT_SPACE_HOLD_MAX = 16;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  localparam logic [1:0] KIND_NAME     = 2'd0;
  localparam logic [1:0] KIND_VALUE    = 2'd1;
  localparam logic [1:0] KIND_PAIR_END = 2'd2;
  localparam logic [1:0] KIND_HDR_END  = 2'd3;

  typedef enum logic [1:0] {
    MODE_SKIP,
    MODE_NAME,
    MODE_VALUE,
    MODE_STOP
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NAME_RD,
    ST_NAME_OUT,
    ST_SPACE_OUT,
    ST_BYTE_OUT,
    ST_PAIR_END,
    ST_HDR_END
  } state_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       header_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       name_overflow;
    logic       run_last;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } emit_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cookie_header_tokenizer.sv
// Cookie header tokenizer top level. A value or marker result goes from the
// sequencer state register into the output register; a name byte is first read
// from the name RAM, then emitted. A beat with no result is taken in idle; after
// other beats, no beat is taken until each held blank, byte or marker is emitted.
// Reset: synchronous active-low rst_n clears the sequencer and output valid;
// the name RAM is not cleared, only entries below the fill count are read.
`default_nettype none

module cookie_header_tokenizer import cht_pkg::*; #(
  parameter int NAME_MAX       = CHT_NAME_MAX,
  parameter int SPACE_HOLD_MAX = CHT_SPACE_HOLD_MAX
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output res_t          out_data
);

  logic  out_valid_r;
  res_t  out_data_r;
  logic  emit_ok;
  emit_t emit_bus;

  // load a new result when the output register is empty or draining
  assign emit_ok = !out_valid_r || out_ready;

  cht_seq #(
    .NAME_MAX       (NAME_MAX),
    .SPACE_HOLD_MAX (SPACE_HOLD_MAX)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .emit_ok  (emit_ok),
    .emit     (emit_bus)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_bus.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_bus.valid) begin
      out_data_r <= emit_bus.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_no_emit_while_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !emit_bus.valid)
    else $error("result emitted while sequencer idle");

  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.header_end |=> !in_ready)
    else $error("header end beat did not start emission");

  a_hdr_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_HDR_END) |->
      out_data.run_last && (out_data.out_byte == 8'h00))
    else $error("header end result malformed");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cht_seq.sv
// Tokenizer sequencer: parse mode tracking, name buffer, held whitespace and
// one-result-per-step emission. Depends on cht_pkg and cht_ram.
`default_nettype none

module cht_seq import cht_pkg::*; #(
  parameter int NAME_MAX       = CHT_NAME_MAX,
  parameter int SPACE_HOLD_MAX = CHT_SPACE_HOLD_MAX
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     emit_ok,
  output emit_t         emit
);

  localparam int NC_W = $clog2(NAME_MAX + 1);
  localparam int AW   = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int SC_W = $clog2(SPACE_HOLD_MAX + 1);

  state_t                    state_r, state_nxt;
  mode_t                     mode_r, mode_nxt;
  logic [NC_W-1:0]           name_cnt_r, name_cnt_nxt;
  logic [NC_W-1:0]           trim_cnt_r, trim_cnt_nxt;
  logic [NC_W-1:0]           idx_r, idx_nxt;
  logic [SC_W-1:0]           sp_cnt_r, sp_cnt_nxt;
  logic [SPACE_HOLD_MAX-1:0] sp_kinds_r, sp_kinds_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      pair_r, pair_nxt;
  logic                      hdr_pend_r, hdr_pend_nxt;
  logic [7:0]                byte_r, byte_nxt;

  logic       accept;
  logic [7:0] b;
  logic       e;
  logic       ws;
  logic       semi;
  logic       eq;
  logic       in_name_grp;
  logic       sep_skip;
  logic       take_name_byte;
  logic       name_full;
  logic       go_name;
  logic       go_value;
  logic       semi_pair;
  logic       name_last;

  logic            ram_we;
  logic            ram_re;
  logic [7:0]      ram_rdata;

  assign accept      = in_valid && in_ready;
  assign b           = in_data.header_byte;
  assign e           = in_data.header_end;
  assign ws          = is_ws(b);
  assign semi        = (b == CH_SEMI);
  assign eq          = (b == CH_EQ);
  assign in_name_grp = (mode_r == MODE_SKIP) || (mode_r == MODE_NAME);
  assign sep_skip    = (mode_r == MODE_SKIP) && (ws || semi);
  assign name_full   = (name_cnt_r == NC_W'(NAME_MAX));

  assign take_name_byte = !e && in_name_grp && !sep_skip && !semi && !eq;
  assign go_name        = !e && in_name_grp && !sep_skip && eq && (trim_cnt_r != '0);
  assign go_value       = !e && (mode_r == MODE_VALUE) && pair_r && !semi && !ws;
  assign semi_pair      = !e && (mode_r == MODE_VALUE) && pair_r && semi;
  assign name_last      = ((idx_r + NC_W'(1)) == trim_cnt_r);

  cht_ram #(
    .WIDTH (8),
    .DEPTH (NAME_MAX),
    .AW    (AW)
  ) u_name_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (name_cnt_r[AW-1:0]),
    .wdata (b),
    .re    (ram_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (e) begin
            state_nxt = ((mode_r == MODE_VALUE) && pair_r) ? ST_PAIR_END : ST_HDR_END;
          end else if (go_name) begin
            state_nxt = ST_NAME_RD;
          end else if (go_value) begin
            state_nxt = (sp_cnt_r != '0) ? ST_SPACE_OUT : ST_BYTE_OUT;
          end else if (semi_pair) begin
            state_nxt = ST_PAIR_END;
          end
        end
      end
      ST_NAME_RD: state_nxt = ST_NAME_OUT;
      ST_NAME_OUT: begin
        if (emit_ok) begin
          state_nxt = name_last ? ST_IDLE : ST_NAME_RD;
        end
      end
      ST_SPACE_OUT: begin
        if (emit_ok && (sp_cnt_r == SC_W'(1))) begin
          state_nxt = ST_BYTE_OUT;
        end
      end
      ST_BYTE_OUT: begin
        if (emit_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAIR_END: begin
        if (emit_ok) begin
          state_nxt = hdr_pend_r ? ST_HDR_END : ST_IDLE;
        end
      end
      ST_HDR_END: begin
        if (emit_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    emit     = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_we   = accept && take_name_byte && !name_full;
      end
      ST_NAME_RD: ram_re = 1'b1;
      ST_NAME_OUT: begin
        emit.valid        = emit_ok;
        emit.res.out_byte = ram_rdata;
        emit.res.kind     = KIND_NAME;
        emit.res.run_last = name_last;
      end
      ST_SPACE_OUT: begin
        emit.valid        = emit_ok;
        emit.res.out_byte = sp_kinds_r[0] ? CH_TAB : CH_SPACE;
        emit.res.kind     = KIND_VALUE;
      end
      ST_BYTE_OUT: begin
        emit.valid        = emit_ok;
        emit.res.out_byte = byte_r;
        emit.res.kind     = KIND_VALUE;
        emit.res.run_last = 1'b1;
      end
      ST_PAIR_END: begin
        emit.valid             = emit_ok;
        emit.res.kind          = KIND_PAIR_END;
        emit.res.name_overflow = ovf_r;
        emit.res.run_last      = !hdr_pend_r;
      end
      ST_HDR_END: begin
        emit.valid        = emit_ok;
        emit.res.kind     = KIND_HDR_END;
        emit.res.run_last = 1'b1;
      end
      default: ;
    endcase
  end

  // Parse state update
  always_comb begin
    mode_nxt     = mode_r;
    name_cnt_nxt = name_cnt_r;
    trim_cnt_nxt = trim_cnt_r;
    idx_nxt      = idx_r;
    sp_cnt_nxt   = sp_cnt_r;
    sp_kinds_nxt = sp_kinds_r;
    ovf_nxt      = ovf_r;
    pair_nxt     = pair_r;
    hdr_pend_nxt = hdr_pend_r;
    byte_nxt     = byte_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (e) begin
            hdr_pend_nxt = 1'b1;
          end else if (in_name_grp) begin
            if (sep_skip) begin
              // drop separator
            end else if (semi) begin
              mode_nxt = MODE_STOP;
            end else if (eq) begin
              pair_nxt     = (trim_cnt_r != '0);
              idx_nxt      = '0;
              sp_cnt_nxt   = '0;
              sp_kinds_nxt = '0;
              mode_nxt     = MODE_VALUE;
            end else begin
              mode_nxt = MODE_NAME;
              if (!name_full) begin
                name_cnt_nxt = name_cnt_r + NC_W'(1);
                if (!ws) begin
                  trim_cnt_nxt = name_cnt_r + NC_W'(1);
                end
              end else if (!ws) begin
                ovf_nxt      = 1'b1;
                trim_cnt_nxt = NC_W'(NAME_MAX);
              end
            end
          end else if (mode_r == MODE_VALUE) begin
            if (semi) begin
              mode_nxt = MODE_SKIP;
              // a named pair clears after its pair-end beat
              if (!pair_r) begin
                name_cnt_nxt = '0;
                trim_cnt_nxt = '0;
                sp_cnt_nxt   = '0;
                sp_kinds_nxt = '0;
                ovf_nxt      = 1'b0;
              end
            end else if (ws) begin
              if (pair_r && (sp_cnt_r < SC_W'(SPACE_HOLD_MAX))) begin
                sp_kinds_nxt = sp_kinds_r |
                               (SPACE_HOLD_MAX'(b == CH_TAB) << sp_cnt_r);
                sp_cnt_nxt   = sp_cnt_r + SC_W'(1);
              end
            end else if (pair_r) begin
              byte_nxt = b;
            end
          end
        end
      end
      ST_NAME_OUT: begin
        if (emit_ok) begin
          idx_nxt = idx_r + NC_W'(1);
        end
      end
      ST_SPACE_OUT: begin
        if (emit_ok) begin
          sp_kinds_nxt = sp_kinds_r >> 1;
          sp_cnt_nxt   = sp_cnt_r - SC_W'(1);
        end
      end
      ST_PAIR_END, ST_HDR_END: begin
        if (emit_ok) begin
          name_cnt_nxt = '0;
          trim_cnt_nxt = '0;
          sp_cnt_nxt   = '0;
          sp_kinds_nxt = '0;
          ovf_nxt      = 1'b0;
          pair_nxt     = 1'b0;
          if (state_r == ST_HDR_END) begin
            mode_nxt     = MODE_SKIP;
            hdr_pend_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      mode_r     <= MODE_SKIP;
      name_cnt_r <= '0;
      trim_cnt_r <= '0;
      idx_r      <= '0;
      sp_cnt_r   <= '0;
      sp_kinds_r <= '0;
      ovf_r      <= 1'b0;
      pair_r     <= 1'b0;
      hdr_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      name_cnt_r <= name_cnt_nxt;
      trim_cnt_r <= trim_cnt_nxt;
      idx_r      <= idx_nxt;
      sp_cnt_r   <= sp_cnt_nxt;
      sp_kinds_r <= sp_kinds_nxt;
      ovf_r      <= ovf_nxt;
      pair_r     <= pair_nxt;
      hdr_pend_r <= hdr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

`default_nettype wire
